[rtl/hsvrgb_pkg.sv]
package hsvrgb_pkg;

	localparam int unsigned HUE_W = 9;
	localparam int unsigned CH_W = 8;
	localparam int unsigned PROD_W = 2 * CH_W;

	// degrees per sector and its fixed-point reciprocal (2^16 / 60, rounded up)
	localparam int unsigned DEG_PER_SECTOR = 60;
	localparam int unsigned RECIP_60 = 1093;
	localparam int unsigned RECIP_SHIFT = 16;
	localparam int unsigned SECTOR_COUNT = 6;
	localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

	typedef enum logic [2:0] {
		SECTOR_RED     = 3'd0,
		SECTOR_YELLOW  = 3'd1,
		SECTOR_GREEN   = 3'd2,
		SECTOR_CYAN    = 3'd3,
		SECTOR_BLUE    = 3'd4,
		SECTOR_MAGENTA = 3'd5
	} sector_t;

	typedef struct packed {
		logic [CH_W-1:0] frac;
		sector_t         sector;
		logic [CH_W-1:0] sat;
		logic [CH_W-1:0] val;
	} s1_t;

	typedef struct packed {
		logic [PROD_W-1:0] fs;
		logic [PROD_W-1:0] gs;
		logic [PROD_W-1:0] pp;
		logic [CH_W-1:0]   val;
		sector_t           sector;
	} s2_t;

	typedef struct packed {
		logic [CH_W-1:0] qa;
		logic [CH_W-1:0] ta;
		logic [CH_W-1:0] p;
		logic [CH_W-1:0] val;
		sector_t         sector;
	} s3_t;

	typedef struct packed {
		logic [PROD_W-1:0] qm;
		logic [PROD_W-1:0] tm;
		logic [CH_W-1:0]   p;
		logic [CH_W-1:0]   val;
		sector_t           sector;
	} s4_t;

	// exact floor(x / 255) for x up to 255 * 255
	function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] sum;
		sum = {1'b0, x} + {{(CH_W+1){1'b0}}, x[PROD_W-1:CH_W]} + {{PROD_W{1'b0}}, 1'b1};
		return sum[PROD_W-1:CH_W];
	endfunction

endpackage

[rtl/hsvrgb_in_if.sv]
interface hsvrgb_in_if;
	logic                         valid;
	logic                         ready;
	logic [hsvrgb_pkg::HUE_W-1:0] hue;
	logic [hsvrgb_pkg::CH_W-1:0]  saturation;
	logic [hsvrgb_pkg::CH_W-1:0]  brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

[rtl/hsvrgb_out_if.sv]
interface hsvrgb_out_if;
	logic                        valid;
	logic                        ready;
	logic [hsvrgb_pkg::CH_W-1:0] red;
	logic [hsvrgb_pkg::CH_W-1:0] green;
	logic [hsvrgb_pkg::CH_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

[rtl/hsv_to_rgb_converter_core.sv]
// hsv to rgb color converter, 8-bit channels
//
// channels: hsv (sink) carries hue in degrees (9 bits), saturation and
// brightness (8 bits each); rgb (source) carries red, green and blue.
// a transfer happens on a rising clk edge with valid and ready both high.
//
// throughput: one transfer per cycle while the receiver keeps up; every
// stage is a plain register slice, so a new color enters each cycle while
// earlier ones are in flight. five register stages (sector decode,
// products, divide by 255, scale by value, divide and channel select)
// lead to rgb.valid, the first loaded at the input transfer edge itself.
//
// when the receiver stalls, the output register holds its result and the
// stages behind it keep filling any empty slots; hsv.ready falls only once
// every stage holds a color. nothing is dropped or repeated.
//
// reset (arst_n low, asynchronous) clears all valid bits; the data registers
// are not reset, and the block accepts input in the first cycle after reset.
module hsv_to_rgb_converter_core (
	input logic          clk,
	input logic          arst_n,
	hsvrgb_in_if.sink    hsv,
	hsvrgb_out_if.source rgb
);
	localparam int unsigned W = hsvrgb_pkg::CH_W;

	// stage 1: hue split into sector and fraction
	logic [W-1:0]        frac;
	hsvrgb_pkg::sector_t sector;
	hsvrgb_pkg::s1_t     data_s1;
	logic                valid_s1;
	logic                ready1;

	// stages 2 to 4 live in the term pipeline
	hsvrgb_pkg::s4_t data_s4;
	logic            valid_s4;
	logic            terms_ready;

	// stage 5: output register
	logic         valid_s5;
	logic         ready5;
	logic [W-1:0] red_s5, green_s5, blue_s5;
	logic [W-1:0] q_val, t_val;
	logic [W-1:0] red_d, green_d, blue_d;

	hsvrgb_sector u_sector (
		.hue    (hsv.hue),
		.frac   (frac),
		.sector (sector)
	);

	assign ready5 = !valid_s5 || rgb.ready;
	assign ready1 = !valid_s1 || terms_ready;
	assign hsv.ready = ready1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready1) begin
			valid_s1 <= hsv.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready1 && hsv.valid) begin
			data_s1.frac <= frac;
			data_s1.sector <= sector;
			data_s1.sat <= hsv.saturation;
			data_s1.val <= hsv.brightness;
		end
	end

	hsvrgb_terms u_terms (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (data_s1),
		.in_valid  (valid_s1),
		.in_ready  (terms_ready),
		.out_data  (data_s4),
		.out_valid (valid_s4),
		.out_ready (ready5)
	);

	// final divide by 255 for q and t
	assign q_val = hsvrgb_pkg::div255(data_s4.qm);
	assign t_val = hsvrgb_pkg::div255(data_s4.tm);

	// sector picks which of v, p, q and t drives each channel
	always_comb begin
		unique case (data_s4.sector)
			hsvrgb_pkg::SECTOR_RED: begin
				red_d = data_s4.val; green_d = t_val; blue_d = data_s4.p;
			end
			hsvrgb_pkg::SECTOR_YELLOW: begin
				red_d = q_val; green_d = data_s4.val; blue_d = data_s4.p;
			end
			hsvrgb_pkg::SECTOR_GREEN: begin
				red_d = data_s4.p; green_d = data_s4.val; blue_d = t_val;
			end
			hsvrgb_pkg::SECTOR_CYAN: begin
				red_d = data_s4.p; green_d = q_val; blue_d = data_s4.val;
			end
			hsvrgb_pkg::SECTOR_BLUE: begin
				red_d = t_val; green_d = data_s4.p; blue_d = data_s4.val;
			end
			default: begin
				red_d = data_s4.val; green_d = data_s4.p; blue_d = q_val;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (ready5) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready5 && valid_s4) begin
			red_s5 <= red_d;
			green_s5 <= green_d;
			blue_s5 <= blue_d;
		end
	end

	assign rgb.valid = valid_s5;
	assign rgb.red = red_s5;
	assign rgb.green = green_s5;
	assign rgb.blue = blue_s5;
endmodule

[rtl/hsvrgb_sector.sv]
module hsvrgb_sector (
	input  logic [hsvrgb_pkg::HUE_W-1:0] hue,
	output logic [hsvrgb_pkg::CH_W-1:0]  frac,
	output hsvrgb_pkg::sector_t          sector
);
	localparam int unsigned RW = hsvrgb_pkg::HUE_W + 11;

	logic [RW-1:0] recip_prod;
	logic [3:0]    quot;
	logic [9:0]    quot_deg;
	logic [5:0]    rem;
	logic [9:0]    rem_x17;
	logic [3:0]    wrapped;

	// hue / 60 by reciprocal, exact over the 9-bit range
	assign recip_prod = RW'(hue) * RW'(hsvrgb_pkg::RECIP_60);
	assign quot = recip_prod[hsvrgb_pkg::RECIP_SHIFT +: 4];
	assign quot_deg = 10'(quot) * 10'(hsvrgb_pkg::DEG_PER_SECTOR);
	assign rem = 6'(10'(hue) - quot_deg);
	// rem * 255 / 60 is rem * 17 / 4
	assign rem_x17 = 10'(rem) * 10'd17;
	assign frac = rem_x17[9:2];
	assign wrapped = (quot >= 4'(hsvrgb_pkg::SECTOR_COUNT))
		? quot - 4'(hsvrgb_pkg::SECTOR_COUNT) : quot;
	assign sector = hsvrgb_pkg::sector_t'(wrapped[2:0]);
endmodule

[rtl/hsvrgb_terms.sv]
module hsvrgb_terms (
	input  logic            clk,
	input  logic            arst_n,
	input  hsvrgb_pkg::s1_t in_data,
	input  logic            in_valid,
	output logic            in_ready,
	output hsvrgb_pkg::s4_t out_data,
	output logic            out_valid,
	input  logic            out_ready
);
	localparam int unsigned W = hsvrgb_pkg::CH_W;
	localparam int unsigned PW = hsvrgb_pkg::PROD_W;

	hsvrgb_pkg::s2_t data_s2;
	hsvrgb_pkg::s3_t data_s3;
	hsvrgb_pkg::s4_t data_s4;
	logic valid_s2, valid_s3, valid_s4;
	logic ready2, ready3, ready4;

	assign ready4 = !valid_s4 || out_ready;
	assign ready3 = !valid_s3 || ready4;
	assign ready2 = !valid_s2 || ready3;
	assign in_ready = ready2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready2) valid_s2 <= in_valid;
			if (ready3) valid_s3 <= valid_s2;
			if (ready4) valid_s4 <= valid_s3;
		end
	end

	// products of the fraction and saturation, and of p before scaling
	always_ff @(posedge clk) begin
		if (ready2 && in_valid) begin
			data_s2.fs <= PW'(in_data.frac) * PW'(in_data.sat);
			data_s2.gs <= PW'(hsvrgb_pkg::FULL_SCALE - in_data.frac) * PW'(in_data.sat);
			data_s2.pp <= PW'(hsvrgb_pkg::FULL_SCALE - in_data.sat) * PW'(in_data.val);
			data_s2.val <= in_data.val;
			data_s2.sector <= in_data.sector;
		end
	end

	// first divide by 255
	always_ff @(posedge clk) begin
		if (ready3 && valid_s2) begin
			data_s3.qa <= hsvrgb_pkg::FULL_SCALE - hsvrgb_pkg::div255(data_s2.fs);
			data_s3.ta <= hsvrgb_pkg::FULL_SCALE - hsvrgb_pkg::div255(data_s2.gs);
			data_s3.p <= hsvrgb_pkg::div255(data_s2.pp);
			data_s3.val <= data_s2.val;
			data_s3.sector <= data_s2.sector;
		end
	end

	// scale q and t by value
	always_ff @(posedge clk) begin
		if (ready4 && valid_s3) begin
			data_s4.qm <= PW'(data_s3.qa) * PW'(data_s3.val);
			data_s4.tm <= PW'(data_s3.ta) * PW'(data_s3.val);
			data_s4.p <= data_s3.p;
			data_s4.val <= W'(data_s3.val);
			data_s4.sector <= data_s3.sector;
		end
	end

	assign out_data = data_s4;
	assign out_valid = valid_s4;
endmodule

[tb/hsvrgb_checker.sv]
module hsvrgb_checker (
	input  logic        clk,
	input  logic        arst_n,
	hsvrgb_in_if        hsv,
	hsvrgb_out_if       rgb,
	output int unsigned fail_count,
	output int unsigned in_flight
);
	typedef struct packed {
		logic [hsvrgb_pkg::CH_W-1:0] red;
		logic [hsvrgb_pkg::CH_W-1:0] green;
		logic [hsvrgb_pkg::CH_W-1:0] blue;
	} color_t;

	color_t pending_colors[$];

	function automatic color_t hsv_to_rgb(input logic [hsvrgb_pkg::HUE_W-1:0] hue,
			input logic [hsvrgb_pkg::CH_W-1:0] sat, input logic [hsvrgb_pkg::CH_W-1:0] val);
		int unsigned h;
		int unsigned s;
		int unsigned v;
		int unsigned fs;
		int unsigned f;
		int unsigned p;
		int unsigned q;
		int unsigned t;
		hsvrgb_pkg::sector_t sector;
		color_t      c;
		h  = hue;
		s  = sat;
		v  = val;
		fs = hsvrgb_pkg::FULL_SCALE;
		// position inside the 60 degree sector, scaled to 0..250
		f = (h % hsvrgb_pkg::DEG_PER_SECTOR) * fs / hsvrgb_pkg::DEG_PER_SECTOR;
		p = (fs - s) * v / fs;
		q = (fs - f * s / fs) * v / fs;
		t = (fs - (fs - f) * s / fs) * v / fs;
		// hues past 359 wrap through the modulo
		sector = hsvrgb_pkg::sector_t'((h / hsvrgb_pkg::DEG_PER_SECTOR)
			% hsvrgb_pkg::SECTOR_COUNT);
		case (sector)
			hsvrgb_pkg::SECTOR_RED:
				c = '{hsvrgb_pkg::CH_W'(v), hsvrgb_pkg::CH_W'(t), hsvrgb_pkg::CH_W'(p)};
			hsvrgb_pkg::SECTOR_YELLOW:
				c = '{hsvrgb_pkg::CH_W'(q), hsvrgb_pkg::CH_W'(v), hsvrgb_pkg::CH_W'(p)};
			hsvrgb_pkg::SECTOR_GREEN:
				c = '{hsvrgb_pkg::CH_W'(p), hsvrgb_pkg::CH_W'(v), hsvrgb_pkg::CH_W'(t)};
			hsvrgb_pkg::SECTOR_CYAN:
				c = '{hsvrgb_pkg::CH_W'(p), hsvrgb_pkg::CH_W'(q), hsvrgb_pkg::CH_W'(v)};
			hsvrgb_pkg::SECTOR_BLUE:
				c = '{hsvrgb_pkg::CH_W'(t), hsvrgb_pkg::CH_W'(p), hsvrgb_pkg::CH_W'(v)};
			default:
				c = '{hsvrgb_pkg::CH_W'(v), hsvrgb_pkg::CH_W'(p), hsvrgb_pkg::CH_W'(q)};
		endcase
		return c;
	endfunction

	initial begin
		fail_count = 0;
		in_flight  = 0;
	end

	always @(posedge clk) begin
		color_t want;
		if (arst_n) begin
			if (hsv.valid && hsv.ready)
				pending_colors.push_back(hsv_to_rgb(hsv.hue, hsv.saturation, hsv.brightness));
			if (rgb.valid && rgb.ready) begin
				if (pending_colors.size() == 0) begin
					$error("rgb transfer with no color pending");
					fail_count++;
				end else begin
					want = pending_colors.pop_front();
					if (rgb.red !== want.red) begin
						$error("red: expected %0d, got %0d", want.red, rgb.red);
						fail_count++;
					end
					if (rgb.green !== want.green) begin
						$error("green: expected %0d, got %0d", want.green, rgb.green);
						fail_count++;
					end
					if (rgb.blue !== want.blue) begin
						$error("blue: expected %0d, got %0d", want.blue, rgb.blue);
						fail_count++;
					end
				end
			end
			in_flight = pending_colors.size();
		end
	end
endmodule

[tb/tb.sv]
module tb;
	// generous bound: ~625 colors under the worst gaps and stalls stay well under this
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_COLORS = 600;
	localparam int unsigned DIRECTED_COLORS = 24;
	localparam int unsigned HUE_W = hsvrgb_pkg::HUE_W;
	localparam int unsigned CH_W = hsvrgb_pkg::CH_W;

	logic        clk;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned in_flight;
	int unsigned sent;
	int unsigned cycles;
	// when set, neither side inserts gaps or stalls
	bit          no_idle;

	hsvrgb_in_if  hsv_ch ();
	hsvrgb_out_if rgb_ch ();

	hsv_to_rgb_converter_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv_ch),
		.rgb    (rgb_ch)
	);

	hsvrgb_checker color_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv        (hsv_ch),
		.rgb        (rgb_ch),
		.fail_count (fail_count),
		.in_flight  (in_flight)
	);

	// 10 unit period
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog, also catches colors that never come out
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// one color on the hsv channel; called and returning at a falling edge.
	// valid is only lowered when a gap is drawn, so back-to-back colors keep
	// it high without a drop inside the same step
	task automatic send_color(input logic [HUE_W-1:0] hue, input logic [CH_W-1:0] sat,
			input logic [CH_W-1:0] bri);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			hsv_ch.valid      <= 1'b0;
			// junk on the payload while idle, the block must ignore it
			hsv_ch.hue        <= HUE_W'($urandom);
			hsv_ch.saturation <= CH_W'($urandom);
			hsv_ch.brightness <= CH_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		hsv_ch.valid      <= 1'b1;
		hsv_ch.hue        <= hue;
		hsv_ch.saturation <= sat;
		hsv_ch.brightness <= bri;
		// transfer happens on the rising edge where ready is seen high
		do @(posedge clk); while (!hsv_ch.ready);
		sent++;
		@(negedge clk);
	endtask

	// rgb sink: a fresh random stall before each result unless no_idle is set
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				rgb_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rgb_ch.ready <= 1'b1;
			do @(posedge clk); while (!rgb_ch.valid);
			@(negedge clk);
		end
	end

	initial begin
		// sector edges, wrapped hues, grey (zero saturation), black (zero value)
		static int unsigned dir_hue [DIRECTED_COLORS] = '{
			0, 59, 60, 119, 120, 180, 240, 300, 359, 360, 419, 420,
			479, 480, 511, 30, 200, 90, 511, 1, 255, 256, 0, 345};
		static int unsigned dir_sat [DIRECTED_COLORS] = '{
			255, 255, 255, 255, 255, 255, 255, 255, 255, 200, 255, 255,
			128, 255, 255, 0, 0, 255, 0, 1, 170, 85, 0, 255};
		static int unsigned dir_bri [DIRECTED_COLORS] = '{
			255, 255, 255, 200, 255, 255, 255, 255, 255, 255, 128, 255,
			255, 255, 255, 200, 255, 0, 0, 1, 85, 170, 0, 254};
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  sat;
		logic [CH_W-1:0]  bri;

		// every input known from time zero
		arst_n            = 1'b0;
		no_idle           = 1'b0;
		sent              = 0;
		hsv_ch.valid      = 1'b0;
		hsv_ch.hue        = '0;
		hsv_ch.saturation = '0;
		hsv_ch.brightness = '0;
		rgb_ch.ready      = 1'b0;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed colors
		for (int i = 0; i < DIRECTED_COLORS; i++)
			send_color(HUE_W'(dir_hue[i]), CH_W'(dir_sat[i]), CH_W'(dir_bri[i]));

		// random colors, with stretches at full rate on both sides
		for (int i = 0; i < RANDOM_COLORS; i++) begin
			if (i % 100 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			case ($urandom_range(0, 9))
				0: hue = HUE_W'($urandom_range(360, 511));
				// just at or just before a sector boundary
				1: hue = HUE_W'(60 * $urandom_range(0, 7) + ($urandom_range(0, 1) ? 59 : 0));
				2, 3: hue = HUE_W'($urandom_range(0, 511));
				default: hue = HUE_W'($urandom_range(0, 359));
			endcase
			if ($urandom_range(0, 7) == 0)
				sat = $urandom_range(0, 1) ? hsvrgb_pkg::FULL_SCALE : '0;
			else
				sat = CH_W'($urandom_range(0, 255));
			if ($urandom_range(0, 7) == 0)
				bri = $urandom_range(0, 1) ? hsvrgb_pkg::FULL_SCALE : '0;
			else
				bri = CH_W'($urandom_range(0, 255));
			send_color(hue, sat, bri);
		end
		hsv_ch.valid <= 1'b0;

		// drain the pipe, then keep waiting for anything stray
		while (in_flight != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("covered %0d colors: sector edges, hues past 359, grey and black cases,",
			sent);
		$display("random hsv under random gaps and rgb stalls with full-rate stretches");
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
